// ----- sv/dmc_pkg.sv -----
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Maze carver package
// Shared sizes, register indexes, heading codes, the stack entry layout, the
// controller command and status bundles, and the direction ordering table.
// ----------------------------------------------------------------------------
package dmc_pkg;

    localparam int MAX_SIDE  = 32;
    localparam int MAX_CELLS = 1024;
    localparam int COORD_W   = 5;
    localparam int SIDE_W    = 6;
    localparam int STACK_AW  = 10;
    localparam int COUNT_W   = 11;
    localparam int ORDER_W   = 5;
    localparam int POS_W     = 3;
    localparam int DIR_W     = 2;
    localparam int CFG_AW    = 2;
    localparam int CFG_DW    = 6;
    localparam int ORDER_MAX = 23;

    localparam logic [CFG_AW-1:0] REG_GRID_WIDTH  = 2'd0;
    localparam logic [CFG_AW-1:0] REG_GRID_HEIGHT = 2'd1;
    localparam logic [CFG_AW-1:0] REG_START_X     = 2'd2;
    localparam logic [CFG_AW-1:0] REG_START_Y     = 2'd3;

    localparam logic [DIR_W-1:0] DIR_NORTH = 2'd0;
    localparam logic [DIR_W-1:0] DIR_EAST  = 2'd1;
    localparam logic [DIR_W-1:0] DIR_SOUTH = 2'd2;
    localparam logic [DIR_W-1:0] DIR_WEST  = 2'd3;

    typedef struct packed {
        logic [COORD_W-1:0] x;
        logic [COORD_W-1:0] y;
        logic [ORDER_W-1:0] order;
        logic [POS_W-1:0]   pos;
    } walk_entry_t;

    typedef struct packed {
        logic start;
        logic set_order;
        logic clear_row;
        logic step;
        logic pop;
        logic load_top;
        logic push;
        logic finish;
    } cmd_t;

    typedef struct packed {
        logic generating;
        logic pos_end;
        logic in_bounds;
        logic visited_hit;
        logic stack_full;
        logic last_entry;
        logic clear_last;
        logic out_busy;
    } status_t;

    function automatic logic [DIR_W-1:0] perm_dir(input logic [ORDER_W-1:0] order,
                                                  input logic [1:0] pos);
        logic [4*DIR_W-1:0] row;
        logic [DIR_W-1:0]   dir;
        case (order)
            5'd0:    row = {DIR_NORTH, DIR_EAST,  DIR_SOUTH, DIR_WEST};
            5'd1:    row = {DIR_NORTH, DIR_EAST,  DIR_WEST,  DIR_SOUTH};
            5'd2:    row = {DIR_NORTH, DIR_SOUTH, DIR_EAST,  DIR_WEST};
            5'd3:    row = {DIR_NORTH, DIR_SOUTH, DIR_WEST,  DIR_EAST};
            5'd4:    row = {DIR_NORTH, DIR_WEST,  DIR_EAST,  DIR_SOUTH};
            5'd5:    row = {DIR_NORTH, DIR_WEST,  DIR_SOUTH, DIR_EAST};
            5'd6:    row = {DIR_EAST,  DIR_NORTH, DIR_SOUTH, DIR_WEST};
            5'd7:    row = {DIR_EAST,  DIR_NORTH, DIR_WEST,  DIR_SOUTH};
            5'd8:    row = {DIR_EAST,  DIR_SOUTH, DIR_NORTH, DIR_WEST};
            5'd9:    row = {DIR_EAST,  DIR_SOUTH, DIR_WEST,  DIR_NORTH};
            5'd10:   row = {DIR_EAST,  DIR_WEST,  DIR_NORTH, DIR_SOUTH};
            5'd11:   row = {DIR_EAST,  DIR_WEST,  DIR_SOUTH, DIR_NORTH};
            5'd12:   row = {DIR_SOUTH, DIR_NORTH, DIR_EAST,  DIR_WEST};
            5'd13:   row = {DIR_SOUTH, DIR_NORTH, DIR_WEST,  DIR_EAST};
            5'd14:   row = {DIR_SOUTH, DIR_EAST,  DIR_NORTH, DIR_WEST};
            5'd15:   row = {DIR_SOUTH, DIR_EAST,  DIR_WEST,  DIR_NORTH};
            5'd16:   row = {DIR_SOUTH, DIR_WEST,  DIR_NORTH, DIR_EAST};
            5'd17:   row = {DIR_SOUTH, DIR_WEST,  DIR_EAST,  DIR_NORTH};
            5'd18:   row = {DIR_WEST,  DIR_NORTH, DIR_EAST,  DIR_SOUTH};
            5'd19:   row = {DIR_WEST,  DIR_NORTH, DIR_SOUTH, DIR_EAST};
            5'd20:   row = {DIR_WEST,  DIR_EAST,  DIR_NORTH, DIR_SOUTH};
            5'd21:   row = {DIR_WEST,  DIR_EAST,  DIR_SOUTH, DIR_NORTH};
            5'd22:   row = {DIR_WEST,  DIR_SOUTH, DIR_NORTH, DIR_EAST};
            default: row = {DIR_WEST,  DIR_SOUTH, DIR_EAST,  DIR_NORTH};
        endcase
        case (pos)
            2'd0:    dir = row[7:6];
            2'd1:    dir = row[5:4];
            2'd2:    dir = row[3:2];
            default: dir = row[1:0];
        endcase
        return dir;
    endfunction

endpackage
`default_nettype wire

// ----- sv/dmc_ctrl.sv -----
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Maze carver controller
// Sequences start, visited map clearing, neighbor checks, backtracking and
// result issue by commands to the datapath.
// ----------------------------------------------------------------------------
module dmc_ctrl
(
    input  wire logic             clk,
    input  wire logic             rst_n,
    input  wire logic             in_valid,
    output logic                  in_stall,
    input  dmc_pkg::status_t      status,
    output dmc_pkg::cmd_t         cmd
);

    typedef enum logic [2:0] {
        S_IDLE,
        S_CLEAR,
        S_SEARCH,
        S_CHECK,
        S_LOAD
    } state_t;

    state_t state_reg;
    state_t state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        cmd        = '0;
        case (state_reg)
            S_IDLE:
            begin
                if (in_valid)
                begin
                    if (!status.generating)
                    begin
                        cmd.start  = 1'b1;
                        state_next = S_CLEAR;
                    end
                    else
                    begin
                        cmd.set_order = 1'b1;
                        state_next    = S_SEARCH;
                    end
                end
            end
            S_CLEAR:
            begin
                cmd.clear_row = 1'b1;
                if (status.clear_last)
                begin
                    state_next = S_SEARCH;
                end
            end
            S_SEARCH:
            begin
                if (status.pos_end)
                begin
                    if (status.last_entry)
                    begin
                        if (!status.out_busy)
                        begin
                            cmd.finish = 1'b1;
                            state_next = S_IDLE;
                        end
                    end
                    else
                    begin
                        cmd.pop    = 1'b1;
                        state_next = S_LOAD;
                    end
                end
                else
                begin
                    cmd.step = 1'b1;
                    if (status.in_bounds)
                    begin
                        state_next = S_CHECK;
                    end
                end
            end
            S_CHECK:
            begin
                if (status.visited_hit || status.stack_full)
                begin
                    state_next = S_SEARCH;
                end
                else if (!status.out_busy)
                begin
                    cmd.push   = 1'b1;
                    state_next = S_IDLE;
                end
            end
            S_LOAD:
            begin
                cmd.load_top = 1'b1;
                state_next   = S_SEARCH;
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    assign in_stall = (state_reg != S_IDLE);

endmodule
`default_nettype wire

// ----- sv/dmc_datapath.sv -----
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Maze carver datapath
// Configuration registers, the top-of-stack register, the stack and visited
// memories, neighbor computation and the result register.
// ----------------------------------------------------------------------------
module dmc_datapath
(
    input  wire logic                           clk,
    input  wire logic                           rst_n,
    input  wire logic                           cfg_write,
    input  wire logic [dmc_pkg::CFG_AW-1:0]     cfg_index,
    input  wire logic [dmc_pkg::CFG_DW-1:0]     cfg_data,
    input  wire logic [dmc_pkg::ORDER_W-1:0]    order_index,
    input  dmc_pkg::cmd_t                       cmd,
    output dmc_pkg::status_t                    status,
    output logic                                out_valid,
    input  wire logic                           out_stall,
    output logic [dmc_pkg::COORD_W-1:0]         from_x,
    output logic [dmc_pkg::COORD_W-1:0]         from_y,
    output logic [dmc_pkg::DIR_W-1:0]           heading,
    output logic [dmc_pkg::COORD_W-1:0]         to_x,
    output logic [dmc_pkg::COORD_W-1:0]         to_y,
    output logic                                done_res
);

    logic [dmc_pkg::SIDE_W-1:0]   width_reg;
    logic [dmc_pkg::SIDE_W-1:0]   height_reg;
    logic [dmc_pkg::COORD_W-1:0]  start_x_reg;
    logic [dmc_pkg::COORD_W-1:0]  start_y_reg;
    logic [dmc_pkg::COUNT_W-1:0]  count_reg;
    logic                         generating_reg;
    logic [dmc_pkg::COORD_W-1:0]  clr_row_reg;
    logic                         out_valid_reg;

    dmc_pkg::walk_entry_t         top_reg;
    dmc_pkg::walk_entry_t         stack_rd_reg;
    logic [dmc_pkg::COORD_W-1:0]  nx_reg;
    logic [dmc_pkg::COORD_W-1:0]  ny_reg;
    logic [dmc_pkg::DIR_W-1:0]    dir_reg;
    logic [dmc_pkg::MAX_SIDE-1:0] vis_row_reg;

    logic [dmc_pkg::COORD_W-1:0]  from_x_reg;
    logic [dmc_pkg::COORD_W-1:0]  from_y_reg;
    logic [dmc_pkg::DIR_W-1:0]    heading_reg;
    logic [dmc_pkg::COORD_W-1:0]  to_x_reg;
    logic [dmc_pkg::COORD_W-1:0]  to_y_reg;
    logic                         done_reg;

    dmc_pkg::walk_entry_t         stack_mem [dmc_pkg::MAX_CELLS];
    logic [dmc_pkg::MAX_SIDE-1:0] visited_mem [dmc_pkg::MAX_SIDE];

    logic [dmc_pkg::SIDE_W-1:0]   w_eff;
    logic [dmc_pkg::SIDE_W-1:0]   h_eff;
    logic [dmc_pkg::SIDE_W-1:0]   w_last;
    logic [dmc_pkg::SIDE_W-1:0]   h_last;
    logic [dmc_pkg::COORD_W-1:0]  sx;
    logic [dmc_pkg::COORD_W-1:0]  sy;
    logic [dmc_pkg::ORDER_W-1:0]  ord_sat;
    logic [dmc_pkg::DIR_W-1:0]    dir;
    logic [dmc_pkg::COORD_W-1:0]  nx;
    logic [dmc_pkg::COORD_W-1:0]  ny;
    logic                         blocked;
    logic                         in_bounds;
    logic [dmc_pkg::COUNT_W-1:0]  count_m1;
    logic [dmc_pkg::COUNT_W-1:0]  count_m2;
    logic                         vis_we;
    logic [dmc_pkg::COORD_W-1:0]  vis_waddr;
    logic [dmc_pkg::MAX_SIDE-1:0] vis_wdata;
    logic [dmc_pkg::MAX_SIDE-1:0] start_bit;
    logic [dmc_pkg::MAX_SIDE-1:0] new_bit;

    always_comb
    begin
        if (width_reg == '0)
        begin
            w_eff = dmc_pkg::SIDE_W'(1);
        end
        else if (width_reg > dmc_pkg::SIDE_W'(dmc_pkg::MAX_SIDE))
        begin
            w_eff = dmc_pkg::SIDE_W'(dmc_pkg::MAX_SIDE);
        end
        else
        begin
            w_eff = width_reg;
        end
        if (height_reg == '0)
        begin
            h_eff = dmc_pkg::SIDE_W'(1);
        end
        else if (height_reg > dmc_pkg::SIDE_W'(dmc_pkg::MAX_SIDE))
        begin
            h_eff = dmc_pkg::SIDE_W'(dmc_pkg::MAX_SIDE);
        end
        else
        begin
            h_eff = height_reg;
        end
    end

    assign w_last = w_eff - 1'b1;
    assign h_last = h_eff - 1'b1;
    assign sx = ({1'b0, start_x_reg} > w_last) ? w_last[dmc_pkg::COORD_W-1:0] : start_x_reg;
    assign sy = ({1'b0, start_y_reg} > h_last) ? h_last[dmc_pkg::COORD_W-1:0] : start_y_reg;
    assign ord_sat = (order_index > dmc_pkg::ORDER_W'(dmc_pkg::ORDER_MAX))
                   ? dmc_pkg::ORDER_W'(dmc_pkg::ORDER_MAX) : order_index;

    // The neighbor in the direction that the top cell tries next.
    assign dir = dmc_pkg::perm_dir(top_reg.order, top_reg.pos[1:0]);

    // Both coordinates are checked against the grid, since the grid may shrink
    // while cells outside it are still on the stack.
    always_comb
    begin
        nx      = top_reg.x;
        ny      = top_reg.y;
        blocked = 1'b0;
        case (dir)
            dmc_pkg::DIR_NORTH:
            begin
                ny      = top_reg.y - 1'b1;
                blocked = (top_reg.y == '0);
            end
            dmc_pkg::DIR_EAST:
            begin
                nx      = top_reg.x + 1'b1;
                blocked = (top_reg.x == '1);
            end
            dmc_pkg::DIR_SOUTH:
            begin
                ny      = top_reg.y + 1'b1;
                blocked = (top_reg.y == '1);
            end
            default:
            begin
                nx      = top_reg.x - 1'b1;
                blocked = (top_reg.x == '0);
            end
        endcase
        in_bounds = !blocked && ({1'b0, nx} < w_eff) && ({1'b0, ny} < h_eff);
    end

    assign count_m1 = count_reg - 1'b1;
    assign count_m2 = count_reg - 2'd2;

    assign start_bit = dmc_pkg::MAX_SIDE'(1) << top_reg.x;
    assign new_bit   = dmc_pkg::MAX_SIDE'(1) << nx_reg;

    // The clearing sweep writes the start cell's row with its bit already set.
    always_comb
    begin
        vis_we    = 1'b0;
        vis_waddr = ny_reg;
        vis_wdata = vis_row_reg | new_bit;
        if (cmd.clear_row)
        begin
            vis_we    = 1'b1;
            vis_waddr = clr_row_reg;
            vis_wdata = (clr_row_reg == top_reg.y) ? start_bit : '0;
        end
        else if (cmd.push)
        begin
            vis_we = 1'b1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (vis_we)
        begin
            visited_mem[vis_waddr] <= vis_wdata;
        end
        if (cmd.step)
        begin
            vis_row_reg <= visited_mem[ny];
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.push)
        begin
            stack_mem[count_m1[dmc_pkg::STACK_AW-1:0]] <= top_reg;
        end
        if (cmd.pop)
        begin
            stack_rd_reg <= stack_mem[count_m2[dmc_pkg::STACK_AW-1:0]];
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.start)
        begin
            top_reg <= '{x: sx, y: sy, order: ord_sat, pos: '0};
        end
        else if (cmd.set_order)
        begin
            top_reg.order <= ord_sat;
        end
        else if (cmd.step)
        begin
            top_reg.pos <= top_reg.pos + 1'b1;
        end
        else if (cmd.push)
        begin
            top_reg <= '{x: nx_reg, y: ny_reg, order: '0, pos: '0};
        end
        else if (cmd.load_top)
        begin
            top_reg <= stack_rd_reg;
        end
        if (cmd.step)
        begin
            nx_reg  <= nx;
            ny_reg  <= ny;
            dir_reg <= dir;
        end
        if (cmd.push)
        begin
            from_x_reg  <= top_reg.x;
            from_y_reg  <= top_reg.y;
            heading_reg <= dir_reg;
            to_x_reg    <= nx_reg;
            to_y_reg    <= ny_reg;
            done_reg    <= 1'b0;
        end
        else if (cmd.finish)
        begin
            from_x_reg  <= '0;
            from_y_reg  <= '0;
            heading_reg <= '0;
            to_x_reg    <= '0;
            to_y_reg    <= '0;
            done_reg    <= 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            width_reg      <= dmc_pkg::SIDE_W'(dmc_pkg::MAX_SIDE);
            height_reg     <= dmc_pkg::SIDE_W'(dmc_pkg::MAX_SIDE);
            start_x_reg    <= '0;
            start_y_reg    <= '0;
            count_reg      <= '0;
            generating_reg <= 1'b0;
            clr_row_reg    <= '0;
            out_valid_reg  <= 1'b0;
        end
        else
        begin
            if (cfg_write)
            begin
                case (cfg_index)
                    dmc_pkg::REG_GRID_WIDTH:  width_reg   <= cfg_data;
                    dmc_pkg::REG_GRID_HEIGHT: height_reg  <= cfg_data;
                    dmc_pkg::REG_START_X:     start_x_reg <= cfg_data[dmc_pkg::COORD_W-1:0];
                    dmc_pkg::REG_START_Y:     start_y_reg <= cfg_data[dmc_pkg::COORD_W-1:0];
                    default:
                    begin
                    end
                endcase
            end
            if (cmd.start)
            begin
                count_reg      <= dmc_pkg::COUNT_W'(1);
                generating_reg <= 1'b1;
                clr_row_reg    <= '0;
            end
            else if (cmd.push)
            begin
                count_reg <= count_reg + 1'b1;
            end
            else if (cmd.pop)
            begin
                count_reg <= count_m1;
            end
            else if (cmd.finish)
            begin
                count_reg      <= '0;
                generating_reg <= 1'b0;
            end
            if (cmd.clear_row)
            begin
                clr_row_reg <= clr_row_reg + 1'b1;
            end
            if (cmd.push || cmd.finish)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (!out_stall)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    assign status.generating  = generating_reg;
    assign status.pos_end     = (top_reg.pos >= dmc_pkg::POS_W'(4));
    assign status.in_bounds   = in_bounds;
    assign status.visited_hit = vis_row_reg[nx_reg];
    assign status.stack_full  = (count_reg >= dmc_pkg::COUNT_W'(dmc_pkg::MAX_CELLS));
    assign status.last_entry  = (count_reg == dmc_pkg::COUNT_W'(1));
    assign status.clear_last  = (clr_row_reg == dmc_pkg::COORD_W'(dmc_pkg::MAX_SIDE - 1));
    assign status.out_busy    = out_valid_reg && out_stall;

    assign out_valid = out_valid_reg;
    assign from_x    = from_x_reg;
    assign from_y    = from_y_reg;
    assign heading   = heading_reg;
    assign to_x      = to_x_reg;
    assign to_y      = to_y_reg;
    assign done_res  = done_reg;

endmodule
`default_nettype wire

// ----- sv/dfs_maze_carver_core.sv -----
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Depth-first maze carver
// Each transfer yields a result once an open neighbor is found; each
// blocked direction and each backtrack pop adds delay, set by the single-port
// visited row memory and stack memory reads.
// The first item of a maze adds a sweep that clears all 32 visited rows.
// The core takes one item at a time and holds in_stall until it is through.
// Reset clears the control state and sets the grid to 32 by 32 from (0, 0).
// ----------------------------------------------------------------------------
module dfs_maze_carver_core
(
    input  wire logic                           clk,
    input  wire logic                           rst_n,
    input  wire logic                           cfg_write,
    input  wire logic [dmc_pkg::CFG_AW-1:0]     cfg_index,
    input  wire logic [dmc_pkg::CFG_DW-1:0]     cfg_data,
    input  wire logic                           in_valid,
    output logic                                in_stall,
    input  wire logic [dmc_pkg::ORDER_W-1:0]    order_index,
    output logic                                out_valid,
    input  wire logic                           out_stall,
    output logic [dmc_pkg::COORD_W-1:0]         from_x,
    output logic [dmc_pkg::COORD_W-1:0]         from_y,
    output logic [dmc_pkg::DIR_W-1:0]           heading,
    output logic [dmc_pkg::COORD_W-1:0]         to_x,
    output logic [dmc_pkg::COORD_W-1:0]         to_y,
    output logic                                done_res
);

    dmc_pkg::cmd_t    cmd;
    dmc_pkg::status_t status;

    dmc_ctrl u_ctrl
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .in_stall (in_stall),
        .status   (status),
        .cmd      (cmd)
    );

    dmc_datapath u_datapath
    (
        .clk         (clk),
        .rst_n       (rst_n),
        .cfg_write   (cfg_write),
        .cfg_index   (cfg_index),
        .cfg_data    (cfg_data),
        .order_index (order_index),
        .cmd         (cmd),
        .status      (status),
        .out_valid   (out_valid),
        .out_stall   (out_stall),
        .from_x      (from_x),
        .from_y      (from_y),
        .heading     (heading),
        .to_x        (to_x),
        .to_y        (to_y),
        .done_res    (done_res)
    );

endmodule
`default_nettype wire
